>>> design/rzs_pkg.sv
`default_nettype none

package rzs_pkg;

   // Field widths fixed by the interface
   localparam int PRICE_W     = 24;
   localparam int SPREAD_W    = PRICE_W + 1;
   localparam int MAG_W       = PRICE_W;
   localparam int THR_W       = 12;
   localparam int THR_SQ_W    = 2 * THR_W;
   localparam int SIG_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = THR_W;

   // Scale of the squared deviation against a squared Q8 threshold
   localparam int SQ_SHIFT = 16;

   // Result codes
   localparam logic [SIG_W-1:0] SIG_NONE  = 2'd0;
   localparam logic [SIG_W-1:0] SIG_HIGH  = 2'd1;
   localparam logic [SIG_W-1:0] SIG_LOW   = 2'd2;
   localparam logic [SIG_W-1:0] SIG_CLOSE = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EXIT  = 2'd1;

   // Queue occupancy seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> design/rzs_queue.sv
`default_nettype none

module rzs_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 pop,
   output logic [WIDTH-1:0]          rd_data,
   output rzs_pkg::q_status_type     status
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> design/rzs_mul.sv
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle; stops early once the
// remaining multiplier bits are zero.
module rzs_mul #(
   parameter int AW = 8,
   parameter int BW = 8,
   parameter int PW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [AW-1:0] a,
   input  wire logic [BW-1:0] b,
   output logic               idle,
   output logic [PW-1:0]      product
);

   logic [AW-1:0] a_ff, a_in;
   logic [PW-1:0] b_ff, b_in;
   logic [PW-1:0] acc_ff, acc_in;

   assign idle    = (a_ff == '0);
   assign product = acc_ff;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (start) begin
         a_in   = a;
         b_in   = PW'(b);
         acc_in = '0;
      end else if (!idle) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         b_in = b_ff << 1;
         a_in = a_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else begin
         a_ff <= a_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

>>> design/rzs_front.sv
`default_nettype none

module rzs_front #(
   parameter  int WINDOW = 8,
   localparam int KW     = $clog2(WINDOW + 1),
   localparam int SUM_W  = rzs_pkg::SPREAD_W + KW,
   localparam int DW     = rzs_pkg::SPREAD_W + 1 + KW,
   localparam int V_W    = 2 * rzs_pkg::MAG_W + 2 * KW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rzs_pkg::PRICE_W-1:0]   req_price_a,
   input  wire logic [rzs_pkg::PRICE_W-1:0]   req_price_b,
   input  wire rzs_pkg::q_status_type         q_status,
   output logic                               q_push,
   output logic signed [DW-1:0]               q_d,
   output logic signed [SUM_W-1:0]            q_sum,
   output logic [V_W-1:0]                     q_wq
);

   localparam int SQ_W  = 2 * rzs_pkg::MAG_W + KW;
   localparam int XSQ_W = 2 * rzs_pkg::MAG_W;
   localparam int CW    = $clog2(WINDOW);
   localparam int FW    = KW;
   localparam int XW    = rzs_pkg::SPREAD_W;

   localparam logic signed [DW-1:0] W_D = DW'(WINDOW);
   localparam logic [V_W-1:0]       W_V = V_W'(WINDOW);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQO  = 3'd2;
   localparam logic [2:0] ST_WQ   = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [CW-1:0]            slot_ff, slot_in;
   logic [FW-1:0]            fill_ff, fill_in;

   logic signed [XW-1:0]     ring [WINDOW];
   logic signed [XW-1:0]     old_ff;
   logic signed [XW-1:0]     x_ff, x_in;
   logic                     score_ff, score_in;
   logic [XSQ_W-1:0]         xsq_ff, xsq_in;
   logic [XSQ_W-1:0]         oldsq_ff, oldsq_in;
   logic signed [DW-1:0]     d_ff, d_in;
   logic [V_W-1:0]           wq_ff, wq_in;

   logic                     accept;
   logic                     ring_wr;
   logic                     done;
   logic [XW-1:0]            x_abs, old_abs;
   logic [rzs_pkg::MAG_W-1:0] x_mag, old_mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign x_in     = XW'({1'b0, req_price_a} - {1'b0, req_price_b});
   assign score_in = (fill_ff == FW'(WINDOW));
   assign x_abs    = x_ff[XW-1] ? XW'(-x_ff) : x_ff;
   assign old_abs  = old_ff[XW-1] ? XW'(-old_ff) : old_ff;
   assign x_mag    = x_abs[rzs_pkg::MAG_W-1:0];
   assign old_mag  = old_abs[rzs_pkg::MAG_W-1:0];
   assign xsq_in   = XSQ_W'(x_mag) * XSQ_W'(x_mag);
   assign oldsq_in = XSQ_W'(old_mag) * XSQ_W'(old_mag);
   assign d_in     = W_D * DW'(x_ff) - DW'(sum_ff);
   assign wq_in    = W_V * V_W'(sq_ff);

   // Score against the sums before this spread enters them
   assign q_d   = d_ff;
   assign q_sum = sum_ff;
   assign q_wq  = wq_ff;

   always_comb begin
      state_in = state_ff;
      ring_wr  = 1'b0;
      q_push   = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            ring_wr  = 1'b1;
            state_in = ST_SQO;
         end
         ST_SQO: begin
            state_in = score_ff ? ST_WQ : ST_PUSH;
         end
         ST_WQ: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!score_ff) begin
               done = 1'b1;
            end else if (!q_status.full) begin
               q_push = 1'b1;
               done   = 1'b1;
            end
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Retire the oldest spread once the ring is full; grow the sums while filling
   always_comb begin
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      fill_in = fill_ff;
      slot_in = slot_ff;
      if (done) begin
         if (score_ff) begin
            sum_in = sum_ff - SUM_W'(old_ff) + SUM_W'(x_ff);
            sq_in  = sq_ff - SQ_W'(oldsq_ff) + SQ_W'(xsq_ff);
         end else begin
            sum_in  = sum_ff + SUM_W'(x_ff);
            sq_in   = sq_ff + SQ_W'(xsq_ff);
            fill_in = fill_ff + 1'b1;
         end
         slot_in = (slot_ff == CW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         sq_ff    <= '0;
         slot_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring[slot_ff] <= x_ff;
      end
      if (accept) begin
         old_ff <= ring[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= x_in;
         score_ff <= score_in;
      end
      if (state_ff == ST_SQX) begin
         xsq_ff <= xsq_in;
         d_ff   <= d_in;
      end
      if (state_ff == ST_SQO) begin
         oldsq_ff <= oldsq_in;
      end
      if (state_ff == ST_WQ) begin
         wq_ff <= wq_in;
      end
   end

endmodule

`default_nettype wire

>>> design/rzs_back.sv
`default_nettype none

module rzs_back #(
   parameter  int WINDOW = 8,
   localparam int KW     = $clog2(WINDOW + 1),
   localparam int SUM_W  = rzs_pkg::SPREAD_W + KW,
   localparam int DW     = rzs_pkg::SPREAD_W + 1 + KW,
   localparam int V_W    = 2 * rzs_pkg::MAG_W + 2 * KW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rzs_pkg::q_status_type         q_status,
   output logic                               q_pop,
   input  wire logic signed [DW-1:0]          q_d,
   input  wire logic signed [SUM_W-1:0]       q_sum,
   input  wire logic [V_W-1:0]                q_wq,
   input  wire logic [rzs_pkg::THR_W-1:0]     entry_thr,
   input  wire logic [rzs_pkg::THR_W-1:0]     exit_thr,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rzs_pkg::SIG_W-1:0]          rsp_signal
);

   localparam int AW = DW - 1;
   localparam int BW = V_W;
   localparam int PW = V_W + rzs_pkg::THR_SQ_W;
   localparam int TW = rzs_pkg::THR_SQ_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SD   = 3'd1;
   localparam logic [2:0] ST_WD   = 3'd2;
   localparam logic [2:0] ST_WS   = 3'd3;
   localparam logic [2:0] ST_SE   = 3'd4;
   localparam logic [2:0] ST_WE   = 3'd5;
   localparam logic [2:0] ST_WX   = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rzs_pkg::SIG_W-1:0]  rsp_signal_ff, rsp_signal_in;

   logic signed [DW-1:0]       d_ff;
   logic signed [SUM_W-1:0]    s_ff;
   logic [V_W-1:0]             wq_ff;
   logic [PW-1:0]              lhs_ff, lhs_in;
   logic [BW-1:0]              v_ff, v_in;
   logic                       gte_ff, gte_in;
   logic                       ltx_ff, ltx_in;

   logic                       mul_start, mul_idle;
   logic [AW-1:0]              mul_a;
   logic [BW-1:0]              mul_b;
   logic [PW-1:0]              mul_p;

   logic [DW-1:0]              d_abs;
   logic [SUM_W-1:0]           s_abs;
   logic [AW-1:0]              d_mag;
   logic [AW-1:0]              s_mag;
   logic [TW-1:0]              te, tx;
   logic                       out_free, d_pos, d_neg;
   logic                       load, capture;

   rzs_mul #(
      .AW (AW),
      .BW (BW),
      .PW (PW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .idle    (mul_idle),
      .product (mul_p)
   );

   assign d_abs    = d_ff[DW-1] ? DW'(-d_ff) : d_ff;
   assign s_abs    = s_ff[SUM_W-1] ? SUM_W'(-s_ff) : s_ff;
   assign d_mag    = d_abs[AW-1:0];
   assign s_mag    = AW'(s_abs[SUM_W-2:0]);
   assign te       = TW'(entry_thr) * TW'(entry_thr);
   assign tx       = TW'(exit_thr) * TW'(exit_thr);
   assign d_neg    = d_ff[DW-1];
   assign d_pos    = !d_neg && (d_ff != '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign lhs_in = mul_p << rzs_pkg::SQ_SHIFT;
   assign v_in   = wq_ff - mul_p[BW-1:0];
   assign gte_in = (lhs_ff > mul_p);
   assign ltx_in = (lhs_ff < mul_p);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_signal = rsp_signal_ff;

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      load      = 1'b0;
      capture   = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               state_in = ST_SD;
            end
         end
         ST_SD: begin
            mul_start = 1'b1;
            mul_a     = d_mag;
            mul_b     = BW'(d_mag);
            state_in  = ST_WD;
         end
         ST_WD: begin
            if (mul_idle) begin
               capture   = 1'b1;
               mul_start = 1'b1;
               mul_a     = s_mag;
               mul_b     = BW'(s_mag);
               state_in  = ST_WS;
            end
         end
         ST_WS: begin
            if (mul_idle) begin
               capture  = 1'b1;
               state_in = ST_SE;
            end
         end
         ST_SE: begin
            mul_start = 1'b1;
            mul_a     = AW'(te);
            mul_b     = v_ff;
            state_in  = ST_WE;
         end
         ST_WE: begin
            if (mul_idle) begin
               capture   = 1'b1;
               mul_start = 1'b1;
               mul_a     = AW'(tx);
               mul_b     = v_ff;
               state_in  = ST_WX;
            end
         end
         ST_WX: begin
            if (mul_idle) begin
               capture  = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_signal_in = rsp_signal_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         priority if (d_pos && gte_ff) begin
            rsp_signal_in = rzs_pkg::SIG_HIGH;
         end else if (d_neg && gte_ff) begin
            rsp_signal_in = rzs_pkg::SIG_LOW;
         end else if (ltx_ff) begin
            rsp_signal_in = rzs_pkg::SIG_CLOSE;
         end else begin
            rsp_signal_in = rzs_pkg::SIG_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_signal_ff <= rsp_signal_in;
      if (load) begin
         d_ff  <= q_d;
         s_ff  <= q_sum;
         wq_ff <= q_wq;
      end
      if (capture) begin
         unique case (state_ff)
            ST_WD:   lhs_ff <= lhs_in;
            ST_WS:   v_ff   <= v_in;
            ST_WE:   gte_ff <= gte_in;
            default: ltx_ff <= ltx_in;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/rolling_zscore_pair_signal_unit.sv
`default_nettype none

// Channel   Ports                                   Direction  Handshake
// req       req_price_a, req_price_b                in         req_valid / req_stall
// rsp       rsp_signal                              out        rsp_valid / rsp_stall
// csr       csr_index, csr_wdata                    in         csr_wr_en, no wait
//
// Front end stalls each word through SQX, SQO, WQ (scored only) and PUSH,
// and longer only when the 2-entry queue to the back end is full.
// Back end works each scored word through its single shift-add multiplier.
// Reset is synchronous: it clears sums, fill count and ring pointer and loads the
// 1.0 entry and 0.8 exit thresholds.
// A stalled rsp word holds in the output register while the front keeps taking
// words until the queue to the back end is full.
module rolling_zscore_pair_signal_unit #(
   parameter int WINDOW = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [rzs_pkg::PRICE_W-1:0]        req_price_a,
   input  wire logic [rzs_pkg::PRICE_W-1:0]        req_price_b,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [rzs_pkg::SIG_W-1:0]               rsp_signal,
   input  wire logic                               csr_wr_en,
   input  wire logic [rzs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rzs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int KW    = $clog2(WINDOW + 1);
   localparam int SUM_W = rzs_pkg::SPREAD_W + KW;
   localparam int DW    = rzs_pkg::SPREAD_W + 1 + KW;
   localparam int V_W   = 2 * rzs_pkg::MAG_W + 2 * KW;
   localparam int QW    = DW + SUM_W + V_W;

   // Thresholds are Q8: 1.0 for entry, about 0.8 for exit
   localparam logic [rzs_pkg::THR_W-1:0] ENTRY_RESET = 12'd256;
   localparam logic [rzs_pkg::THR_W-1:0] EXIT_RESET  = 12'd205;

   logic [rzs_pkg::THR_W-1:0] entry_ff, entry_in;
   logic [rzs_pkg::THR_W-1:0] exit_ff, exit_in;

   rzs_pkg::q_status_type     q_status;
   logic                      q_push, q_pop;
   logic [QW-1:0]             q_wr_data, q_rd_data;
   logic signed [DW-1:0]      f_d, b_d;
   logic signed [SUM_W-1:0]   f_sum, b_sum;
   logic [V_W-1:0]            f_wq, b_wq;

   // Configuration: unknown indexes drop silently
   always_comb begin
      entry_in = entry_ff;
      exit_in  = exit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rzs_pkg::REG_ENTRY: entry_in = csr_wdata;
            rzs_pkg::REG_EXIT:  exit_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= ENTRY_RESET;
         exit_ff  <= EXIT_RESET;
      end else begin
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
      end
   end

   // Front: spread, ring, running sums, deviation d and W*Q
   rzs_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_price_a (req_price_a),
      .req_price_b (req_price_b),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_d         (f_d),
      .q_sum       (f_sum),
      .q_wq        (f_wq)
   );

   assign q_wr_data = {f_d, f_sum, f_wq};

   rzs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   assign b_d   = q_rd_data[QW-1 -: DW];
   assign b_sum = q_rd_data[V_W + SUM_W - 1 -: SUM_W];
   assign b_wq  = q_rd_data[V_W-1:0];

   // Back: compare 65536*d^2 against T^2*(W*Q - S^2) and classify
   rzs_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .q_d        (b_d),
      .q_sum      (b_sum),
      .q_wq       (b_wq),
      .entry_thr  (entry_ff),
      .exit_thr   (exit_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_signal (rsp_signal)
   );

endmodule

`default_nettype wire

>>> sim/zscore_signal_checker.sv
`default_nettype none

module zscore_signal_checker
   import rzs_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [PRICE_W-1:0]     req_price_a,
   input  wire logic [PRICE_W-1:0]     req_price_b,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [SIG_W-1:0]       rsp_signal,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          signals_owed,
   output logic [3:0][31:0]            signal_tally
);

   localparam logic [THR_W-1:0] ENTRY_AT_RESET = 12'd256;
   localparam logic [THR_W-1:0] EXIT_AT_RESET  = 12'd205;

   typedef logic signed [SPREAD_W-1:0] spread_type;

   // Shadow of the block's window and thresholds
   spread_type         spread_ring [WINDOW];
   logic signed [63:0] window_sum;
   logic [63:0]        window_sq_sum;
   int                 head_slot;
   int                 spreads_filled;
   logic [THR_W-1:0]   entry_thr;
   logic [THR_W-1:0]   exit_thr;

   logic [SIG_W-1:0]   pending_signals [$];

   // Score one spread against a full window, then retire the oldest slot; while filling, just add it.
   task automatic advance_window(input spread_type x, output bit scored,
                                 output logic [SIG_W-1:0] sig);
      logic signed [63:0] x_wide;
      logic signed [63:0] old_wide;
      logic signed [63:0] deviation;
      logic [63:0]        dev_mag;
      logic [63:0]        sum_mag;
      logic [127:0]       spread_var;
      logic [127:0]       dev_sq;
      logic [127:0]       entry_bound;
      logic [127:0]       exit_bound;
      x_wide = x;
      scored = (spreads_filled >= WINDOW);
      sig    = SIG_NONE;
      if (scored) begin
         deviation   = WINDOW * x_wide - window_sum;
         dev_mag     = (deviation < 0) ? -deviation : deviation;
         sum_mag     = (window_sum < 0) ? -window_sum : window_sum;
         spread_var  = 128'(WINDOW) * 128'(window_sq_sum) - 128'(sum_mag) * 128'(sum_mag);
         dev_sq      = (128'(dev_mag) * 128'(dev_mag)) << SQ_SHIFT;
         entry_bound = 128'(entry_thr) * 128'(entry_thr) * spread_var;
         exit_bound  = 128'(exit_thr) * 128'(exit_thr) * spread_var;
         if (deviation > 0 && dev_sq > entry_bound) begin
            sig = SIG_HIGH;
         end else if (deviation < 0 && dev_sq > entry_bound) begin
            sig = SIG_LOW;
         end else if (dev_sq < exit_bound) begin
            sig = SIG_CLOSE;
         end
         old_wide      = spread_ring[head_slot];
         window_sum    = window_sum - old_wide + x_wide;
         window_sq_sum = window_sq_sum - 64'(old_wide * old_wide) + 64'(x_wide * x_wide);
      end else begin
         window_sum     = window_sum + x_wide;
         window_sq_sum  = window_sq_sum + 64'(x_wide * x_wide);
         spreads_filled = spreads_filled + 1;
      end
      spread_ring[head_slot] = x;
      head_slot = (head_slot + 1) % WINDOW;
   endtask

   always @(posedge clock) begin : watch
      spread_type       x;
      bit               scored;
      logic [SIG_W-1:0] predicted;
      logic [SIG_W-1:0] wanted;
      if (reset) begin
         window_sum     = '0;
         window_sq_sum  = '0;
         head_slot      = 0;
         spreads_filled = 0;
         entry_thr      = ENTRY_AT_RESET;
         exit_thr       = EXIT_AT_RESET;
         mismatch_count = 0;
         signal_tally   = '0;
         pending_signals.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ENTRY: entry_thr = csr_wdata[THR_W-1:0];
               REG_EXIT:  exit_thr  = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         // Retire a signal word before queuing new ones: it cannot belong to this edge.
         if (rsp_valid && !rsp_stall) begin
            if (pending_signals.size() == 0) begin
               $error("rsp_signal: word with no signal pending, expected none, got %0d",
                      rsp_signal);
               mismatch_count = mismatch_count + 1;
            end else begin
               wanted = pending_signals.pop_front();
               signal_tally[wanted] = signal_tally[wanted] + 1;
               if (rsp_signal !== wanted) begin
                  $error("rsp_signal mismatch: expected %0d, got %0d", wanted, rsp_signal);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            x = $signed({1'b0, req_price_a}) - $signed({1'b0, req_price_b});
            advance_window(x, scored, predicted);
            if (scored) begin
               pending_signals.insert(pending_signals.size(), predicted);
            end
         end
      end
      signals_owed <= pending_signals.size();
   end

endmodule

`default_nettype wire

>>> sim/rolling_zscore_pair_signal_unit_tb.sv
`default_nettype none

module rolling_zscore_pair_signal_unit_tb;
   import rzs_pkg::*;

   localparam int WINDOW        = 8;
   localparam int RESET_CYCLES  = 7;
   localparam int SETUP_COUNT   = 7;
   localparam int RANDOM_WORDS  = 175;
   // Covers the back end's slowest scoring pass plus the front end's pipeline
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [PRICE_W-1:0]     PRICE_MAX       = '1;
   localparam logic [THR_W-1:0]       THR_MAX         = '1;
   localparam logic [THR_W-1:0]       THR_ZERO        = '0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;
   // Keep anchors low enough that a spike on top never wraps
   localparam int ANCHOR_CEILING = PRICE_MAX - (1 << 21);

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [PRICE_W-1:0]     req_price_a = '0;
   logic [PRICE_W-1:0]     req_price_b = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [SIG_W-1:0]       rsp_signal;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int               mismatch_count;
   int               signals_owed;
   logic [3:0][31:0] signal_tally;

   // Idle knobs, switched per threshold setup so some stretches run flat out
   bit sender_gaps_on     = 1'b1;
   bit receiver_stalls_on = 1'b1;

   int               rsp_hold_left = 0;
   int               cycle_count   = 0;
   int               words_sent    = 0;
   int               setups_run    = 0;
   logic [PRICE_W-1:0] anchor_a = '0;
   logic [PRICE_W-1:0] anchor_b = '0;
   logic [PRICE_W-1:0] last_a   = '0;
   logic [PRICE_W-1:0] last_b   = '0;

   always #4 clock = ~clock;

   rolling_zscore_pair_signal_unit #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_price_a(req_price_a),
      .req_price_b(req_price_b),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_signal (rsp_signal),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   zscore_signal_checker #(
      .WINDOW(WINDOW)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_price_a   (req_price_a),
      .req_price_b   (req_price_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_signal    (rsp_signal),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .signals_owed  (signals_owed),
      .signal_tally  (signal_tally)
   );

   // Receiver: after each accepted signal word, hold stall for a randomly drawn time, possibly none.
   // The hold also runs down while nothing is offered, so stalls land on every
   // phase of the back end's work.
   always @(posedge clock) begin : receiver
      int hold;
      hold = receiver_stalls_on ? $urandom_range(0, 3) : 0;
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_hold_left <= hold;
         rsp_stall     <= (hold != 0);
      end else if (rsp_hold_left > 1) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_hold_left == 1) begin
         rsp_hold_left <= 0;
         rsp_stall     <= 1'b0;
      end
   end

   // Watchdog: give up if the run hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one price pair and hold it until accepted. Valid drops only ahead of
   // a gap, so a back-to-back word never sees valid lowered and raised in one step.
   task automatic send_pair(input logic [PRICE_W-1:0] price_a, price_b);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_price_a <= price_a;
      req_price_b <= price_b;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_a = price_a;
      last_b = price_b;
      words_sent++;
   endtask

   // Drop valid, wait until every pending signal is back, then let the
   // front end finish any fill-only word that yields nothing.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (signals_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both thresholds, then poke an unmapped index that must change nothing.
   task automatic apply_thresholds(input logic [THR_W-1:0] entry_q8, exit_q8);
      csr_wr_en <= 1'b1;
      csr_index <= REG_ENTRY;
      csr_wdata <= entry_q8;
      @(posedge clock);
      csr_index <= REG_EXIT;
      csr_wdata <= exit_q8;
      @(posedge clock);
      csr_index <= CSR_INDEX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI));
      csr_wdata <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      setups_run++;
   endtask

   // Mostly a correlated pair that jitters around its anchors, so the z-score
   // wanders across the thresholds; the rest is spikes, noise, extremes and repeats.
   task automatic draw_prices(output logic [PRICE_W-1:0] price_a, price_b);
      int mode;
      mode = $urandom_range(0, 15);
      if (mode < 10) begin
         price_a = anchor_a + PRICE_W'($urandom_range(0, 4095));
         price_b = anchor_b + PRICE_W'($urandom_range(0, 4095));
      end else if (mode < 12) begin
         price_a = anchor_a + PRICE_W'($urandom_range(0, 1 << 20));
         price_b = anchor_b + PRICE_W'($urandom_range(0, 1 << 20));
      end else if (mode < 14) begin
         price_a = PRICE_W'($urandom());
         price_b = PRICE_W'($urandom());
      end else if (mode == 14) begin
         price_a = $urandom_range(0, 1) ? PRICE_MAX : '0;
         price_b = $urandom_range(0, 1) ? PRICE_MAX : '0;
      end else begin
         price_a = last_a;
         price_b = last_b;
      end
   endtask

   initial begin : stimulus
      logic [PRICE_W-1:0] pa;
      logic [PRICE_W-1:0] pb;
      logic [THR_W-1:0]   entry_pick;
      int                 scored_total;

      // Hold reset, then release it on a clock edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset thresholds (1.0 entry, 0.8 exit).
      // Fill the ring with one constant spread of 500: no signal words yet.
      for (int i = 0; i < WINDOW; i++) begin
         send_pair(PRICE_W'(500 + i * 1000), PRICE_W'(i * 1000));
      end
      // Zero variance, same spread again: undefined z-score, expect no signal
      send_pair(PRICE_W'(700), PRICE_W'(200));
      // The window still holds one spread; now push the extremes of both fields
      send_pair(PRICE_MAX, '0);
      send_pair('0, PRICE_MAX);
      send_pair('0, '0);
      send_pair(PRICE_MAX, PRICE_MAX);
      send_pair(PRICE_MAX, PRICE_W'(PRICE_MAX - 1));
      send_pair(PRICE_W'(1), PRICE_W'(0));
      send_pair(PRICE_W'(1000), PRICE_W'(500));
      send_pair(PRICE_W'(500), PRICE_W'(500));

      for (int setup = 0; setup < SETUP_COUNT; setup++) begin
         settle();
         // Extremes first: zero entry and exit, saturated both, and the two mixes
         case (setup)
            0: apply_thresholds(THR_ZERO, THR_ZERO);
            1: apply_thresholds(THR_MAX, THR_MAX);
            2: apply_thresholds(THR_MAX, THR_ZERO);
            3: apply_thresholds(THR_ZERO, THR_MAX);
            default: begin
               // Keep entry where the jittering pair often lands
               entry_pick = THR_W'($urandom_range(64, 700));
               apply_thresholds(entry_pick, THR_W'($urandom_range(0, entry_pick)));
            end
         endcase
         sender_gaps_on     = (setup % 3) != 1;
         receiver_stalls_on = (setup % 3) != 2;

         anchor_a = PRICE_W'($urandom_range(0, ANCHOR_CEILING));
         anchor_b = PRICE_W'($urandom_range(0, ANCHOR_CEILING));
         // Flat run: the whole ring holds one spread, so scoring hits zero variance
         repeat ($urandom_range(WINDOW + 1, WINDOW + 4)) send_pair(anchor_a, anchor_b);
         // Step off the flat window while variance is still zero
         send_pair(anchor_a + PRICE_W'(7), anchor_b);

         repeat (RANDOM_WORDS) begin
            draw_prices(pa, pb);
            send_pair(pa, pb);
         end
      end

      settle();

      scored_total = signal_tally[SIG_NONE] + signal_tally[SIG_HIGH]
                   + signal_tally[SIG_LOW] + signal_tally[SIG_CLOSE];
      $display("Sent %0d price pairs over %0d threshold pairs, %0d signal words compared",
               words_sent, setups_run + 1, scored_total);
      $display("Signal mix: %0d high, %0d low, %0d close, %0d none",
               signal_tally[SIG_HIGH], signal_tally[SIG_LOW],
               signal_tally[SIG_CLOSE], signal_tally[SIG_NONE]);
      if (mismatch_count == 0 && signals_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
design/rzs_pkg.sv
design/rzs_queue.sv
design/rzs_mul.sv
design/rzs_front.sv
design/rzs_back.sv
design/rolling_zscore_pair_signal_unit.sv
sim/zscore_signal_checker.sv
sim/rolling_zscore_pair_signal_unit_tb.sv
